// ===== hdl/osd_pkg.sv =====
// Shared widths, payload types and constants for the orthoplex distance pipeline.
`timescale 1ns / 1ps
package osd_pkg;

  localparam int WB       = 32;
  localparam int FB       = 16;
  localparam int QB       = WB - 1;
  localparam int SH       = QB - FB;
  localparam int SQ_W     = 2 * WB + 2;
  localparam int NAX      = 4;
  localparam int DIV_LAT  = QB + 1;
  localparam int SQRT_LAT = QB + 1;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  typedef logic signed [WB-1:0] word_t;
  typedef logic [QB-1:0]        sz_t;

  localparam sz_t            SIZE_RESET = sz_t'(65536);
  localparam sz_t            QMAX       = {QB{1'b1}};
  localparam logic [WB-1:0]  WMAX       = {1'b0, {QB{1'b1}}};
  localparam logic [WB-1:0]  WLIM       = {1'b1, {QB{1'b0}}};
  localparam logic [WB+1:0]  ONE_Q      = (WB+2)'(1) << FB;

  typedef struct packed {
    word_t point_x;
    word_t point_y;
    word_t point_z;
    word_t point_w;
  } in_t;

  typedef struct packed {
    word_t signed_distance;
    word_t nearest_x;
    word_t nearest_y;
    word_t nearest_z;
    word_t nearest_w;
  } out_t;

endpackage

// ===== hdl/orthoplex_signed_distance.sv =====
// Top level: signed distance and nearest point of a scaled 4D cross-polytope.
//
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_stall, in_data             | in
//  result   | out_valid, out_stall, out_data          | out
//  config   | psel, penable, pwrite, paddr, pwdata,   | in/out
//           | prdata, pready                          |
//
// One point enters per cycle while in_stall is low and passes 72 register stages:
// 32 divider stages, seven arithmetic stages and 32 square-root stages plus the
// output register. The whole pipe
// advances whenever the output register is empty or taken, so a stall holds
// every stage and in_stall follows it.
// Reset clears the valid bits and loads the sizes with 1.0.
`timescale 1ns / 1ps
module orthoplex_signed_distance (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  osd_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output osd_pkg::out_t              out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osd_pkg::ADDR_W-1:0] paddr,
  input  logic [osd_pkg::DATA_W-1:0] pwdata,
  output logic [osd_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import osd_pkg::*;

  sz_t   size_r [NAX];
  logic  en;
  word_t pin [NAX];
  logic [WB-1:0] mag_in [NAX];
  sz_t   qd [NAX];

  assign pin[0] = in_data.point_x;
  assign pin[1] = in_data.point_y;
  assign pin[2] = in_data.point_z;
  assign pin[3] = in_data.point_w;

  // config port
  assign pready = 1'b1;
  assign prdata = DATA_W'(size_r[paddr[ADDR_W-1:2]]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAX; i++) size_r[i] <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      size_r[paddr[ADDR_W-1:2]] <= pwdata[QB-1:0];
    end
  end

  logic  out_valid_r;
  out_t  out_r;
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // divider lanes
  for (genvar g = 0; g < NAX; g++) begin : g_div
    assign mag_in[g] = pin[g][WB-1] ? (~pin[g] + 1'b1) : pin[g];
    osd_div u_div (.clk(clk), .en(en), .a(mag_in[g]), .s(size_r[g]), .q(qd[g]));
  end

  logic  dv_r  [DIV_LAT];
  logic  daz_r [DIV_LAT];
  word_t dp_r  [DIV_LAT][NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) dv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_valid;
      for (int k = 1; k < DIV_LAT; k++) dv_r[k] <= dv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      daz_r[0] <= (in_data == '0);
      for (int i = 0; i < NAX; i++) dp_r[0][i] <= pin[i];
      for (int k = 1; k < DIV_LAT; k++) begin
        daz_r[k] <= daz_r[k-1];
        for (int i = 0; i < NAX; i++) dp_r[k][i] <= dp_r[k-1][i];
      end
    end
  end

  // stage A: scaled distance
  logic            a_v_r, a_az_r;
  word_t           a_p_r [NAX];
  sz_t             a_q_r [NAX];
  logic [WB+1:0]   a_d_r, a_d_nxt;

  always_comb begin
    a_d_nxt = '0;
    for (int i = 0; i < NAX; i++) a_d_nxt = a_d_nxt + (WB+2)'(qd[i]);
    a_d_nxt = a_d_nxt - ONE_Q;
  end

  // stage B: shifted quotients
  logic            b_v_r, b_az_r, b_dneg_r;
  word_t           b_p_r [NAX];
  word_t           b_t_r [NAX];
  sz_t             b_s_unused;
  logic signed [WB+1:0] b_fd4;
  logic signed [WB+1:0] b_diff [NAX];
  word_t           b_t_nxt [NAX];

  assign b_s_unused = '0;

  always_comb begin
    b_fd4 = $signed(a_d_r) >>> 2;
    for (int i = 0; i < NAX; i++) begin
      b_diff[i] = $signed({3'b000, a_q_r[i]}) - b_fd4;
      if (b_diff[i][WB+1:WB-1] == 3'b000 || b_diff[i][WB+1:WB-1] == 3'b111)
        b_t_nxt[i] = b_diff[i][WB-1:0];
      else if (b_diff[i][WB+1])
        b_t_nxt[i] = WLIM;
      else
        b_t_nxt[i] = WMAX;
    end
  end

  // stage C: product with size
  logic            c_v_r, c_az_r, c_dneg_r;
  word_t           c_p_r [NAX];
  logic            c_neg_r [NAX];
  logic            c_pz_r [NAX];
  logic [WB+QB-1:0] c_prod_r [NAX];
  logic [WB+QB-1:0] c_prod_nxt [NAX];
  logic [WB-1:0]   c_m [NAX];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      c_m[i] = b_t_r[i][WB-1] ? (~b_t_r[i] + 1'b1) : b_t_r[i];
      c_prod_nxt[i] = (WB+QB)'(c_m[i]) * (WB+QB)'(size_r[i]);
    end
  end

  // stage D: nearest point
  logic            d_v_r, d_az_r, d_dneg_r;
  word_t           d_p_r [NAX];
  word_t           d_n_r [NAX];
  word_t           d_n_nxt [NAX];
  logic [WB+QB-FB-1:0] d_pr [NAX];
  logic [WB-1:0]   d_mag [NAX];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      d_pr[i] = c_prod_r[i][WB+QB-1:FB];
      if (d_pr[i][WB+QB-FB-1:WB] != '0 || d_pr[i][WB-1:0] > WLIM)
        d_mag[i] = WLIM;
      else
        d_mag[i] = d_pr[i][WB-1:0];
      if (c_pz_r[i])
        d_n_nxt[i] = '0;
      else if (c_neg_r[i])
        d_n_nxt[i] = ~d_mag[i] + 1'b1;
      else
        d_n_nxt[i] = (d_mag[i] == WLIM) ? WMAX : d_mag[i];
    end
  end

  // stage E: offset magnitude
  logic            e_v_r, e_az_r, e_dneg_r;
  word_t           e_n_r [NAX];
  logic [WB-1:0]   e_e_r [NAX];
  logic [WB-1:0]   e_e_nxt [NAX];
  logic signed [WB:0] e_dif [NAX];

  always_comb begin
    for (int i = 0; i < NAX; i++) begin
      e_dif[i]   = {d_p_r[i][WB-1], d_p_r[i]} - {d_n_r[i][WB-1], d_n_r[i]};
      e_e_nxt[i] = e_dif[i][WB] ? WB'(-e_dif[i]) : e_dif[i][WB-1:0];
    end
  end

  // stage F: squares
  logic            f_v_r, f_az_r, f_dneg_r;
  word_t           f_n_r [NAX];
  logic [2*WB-1:0] f_sq_r [NAX];

  // stage G: pair sums
  logic            g_v_r, g_az_r, g_dneg_r;
  word_t           g_n_r [NAX];
  logic [SQ_W-2:0] g_s_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0; b_v_r <= 1'b0; c_v_r <= 1'b0;
      d_v_r <= 1'b0; e_v_r <= 1'b0; f_v_r <= 1'b0; g_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= dv_r[DIV_LAT-1];
      b_v_r <= a_v_r; c_v_r <= b_v_r; d_v_r <= c_v_r;
      e_v_r <= d_v_r; f_v_r <= e_v_r; g_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_az_r <= daz_r[DIV_LAT-1];
      a_d_r  <= a_d_nxt;
      b_az_r <= a_az_r;
      b_dneg_r <= a_d_r[WB+1];
      c_az_r <= b_az_r;   c_dneg_r <= b_dneg_r;
      d_az_r <= c_az_r;   d_dneg_r <= c_dneg_r;
      e_az_r <= d_az_r;   e_dneg_r <= d_dneg_r;
      f_az_r <= e_az_r;   f_dneg_r <= e_dneg_r;
      g_az_r <= f_az_r;   g_dneg_r <= f_dneg_r;
      for (int i = 0; i < NAX; i++) begin
        a_p_r[i]    <= dp_r[DIV_LAT-1][i];
        a_q_r[i]    <= qd[i] | b_s_unused;
        b_p_r[i]    <= a_p_r[i];
        b_t_r[i]    <= b_t_nxt[i];
        c_p_r[i]    <= b_p_r[i];
        c_prod_r[i] <= c_prod_nxt[i];
        c_neg_r[i]  <= b_p_r[i][WB-1] ^ b_t_r[i][WB-1];
        c_pz_r[i]   <= (b_p_r[i] == '0);
        d_p_r[i]    <= c_p_r[i];
        d_n_r[i]    <= d_n_nxt[i];
        e_n_r[i]    <= d_n_r[i];
        e_e_r[i]    <= e_e_nxt[i];
        f_n_r[i]    <= e_n_r[i];
        f_sq_r[i]   <= (2*WB)'(e_e_r[i]) * (2*WB)'(e_e_r[i]);
        g_n_r[i]    <= f_n_r[i];
      end
      g_s_r[0] <= {1'b0, f_sq_r[0]} + {1'b0, f_sq_r[1]};
      g_s_r[1] <= {1'b0, f_sq_r[2]} + {1'b0, f_sq_r[3]};
    end
  end

  // square root and side data
  sz_t   root_q;
  logic  sv_r    [SQRT_LAT];
  logic  saz_r   [SQRT_LAT];
  logic  sdneg_r [SQRT_LAT];
  word_t sn_r    [SQRT_LAT][NAX];

  osd_sqrt u_sqrt (.clk(clk), .en(en), .x0(g_s_r[0]), .x1(g_s_r[1]), .root(root_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < SQRT_LAT; k++) sv_r[k] <= 1'b0;
    end else if (en) begin
      sv_r[0] <= g_v_r;
      for (int k = 1; k < SQRT_LAT; k++) sv_r[k] <= sv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      saz_r[0]   <= g_az_r;
      sdneg_r[0] <= g_dneg_r;
      for (int i = 0; i < NAX; i++) sn_r[0][i] <= g_n_r[i];
      for (int k = 1; k < SQRT_LAT; k++) begin
        saz_r[k]   <= saz_r[k-1];
        sdneg_r[k] <= sdneg_r[k-1];
        for (int i = 0; i < NAX; i++) sn_r[k][i] <= sn_r[k-1][i];
      end
    end
  end

  // output register
  out_t  out_nxt;
  word_t half;
  word_t sdist;

  always_comb begin
    half  = WB'(size_r[0] >> 1);
    sdist = sdneg_r[SQRT_LAT-1] ? (~WB'(root_q) + 1'b1) : WB'(root_q);
    if (saz_r[SQRT_LAT-1]) begin
      out_nxt.signed_distance = ~half + 1'b1;
      out_nxt.nearest_x       = half;
      out_nxt.nearest_y       = '0;
      out_nxt.nearest_z       = '0;
      out_nxt.nearest_w       = '0;
    end else begin
      out_nxt.signed_distance = sdist;
      out_nxt.nearest_x       = sn_r[SQRT_LAT-1][0];
      out_nxt.nearest_y       = sn_r[SQRT_LAT-1][1];
      out_nxt.nearest_z       = sn_r[SQRT_LAT-1][2];
      out_nxt.nearest_w       = sn_r[SQRT_LAT-1][3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sv_r[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/osd_div.sv =====
// Pipelined restoring divider: saturated (a << FB) / s, one quotient bit per stage.
`timescale 1ns / 1ps
module osd_div (
  input  logic                 clk,
  input  logic                 en,
  input  logic [osd_pkg::WB-1:0] a,
  input  osd_pkg::sz_t         s,
  output osd_pkg::sz_t         q
);
  import osd_pkg::*;

  sz_t  rem_r [QB+1];
  sz_t  low_r [QB+1];
  sz_t  quo_r [QB+1];
  logic sat_r [QB+1];
  logic az_r  [QB+1];

  sz_t  rem_nxt [QB+1];
  sz_t  low_nxt [QB+1];
  sz_t  quo_nxt [QB+1];
  logic sat_nxt [QB+1];
  logic az_nxt  [QB+1];

  always_comb begin
    rem_nxt[0] = QB'(a >> SH);
    low_nxt[0] = {a[SH-1:0], {FB{1'b0}}};
    quo_nxt[0] = '0;
    az_nxt[0]  = (a == '0);
    sat_nxt[0] = (a != '0) && ({{(QB+SH-WB){1'b0}}, a} >= {s, {SH{1'b0}}});
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [QB:0] shf;
    logic [QB:0] sub;
    logic        ge;
    always_comb begin
      shf = {rem_r[k-1], low_r[k-1][QB-1]};
      sub = shf - {1'b0, s};
      ge  = (shf >= {1'b0, s});
      rem_nxt[k] = ge ? sub[QB-1:0] : shf[QB-1:0];
      low_nxt[k] = low_r[k-1] << 1;
      quo_nxt[k] = {quo_r[k-1][QB-2:0], ge};
      sat_nxt[k] = sat_r[k-1];
      az_nxt[k]  = az_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QB; k++) begin
        rem_r[k] <= rem_nxt[k];
        low_r[k] <= low_nxt[k];
        quo_r[k] <= quo_nxt[k];
        sat_r[k] <= sat_nxt[k];
        az_r[k]  <= az_nxt[k];
      end
    end
  end

  assign q = az_r[QB] ? '0 : (sat_r[QB] ? QMAX : quo_r[QB]);

endmodule

// ===== hdl/osd_sqrt.sv =====
// Pipelined integer square root of a sum of two partial sums, one root bit per stage.
`timescale 1ns / 1ps
module osd_sqrt (
  input  logic                    clk,
  input  logic                    en,
  input  logic [osd_pkg::SQ_W-2:0] x0,
  input  logic [osd_pkg::SQ_W-2:0] x1,
  output osd_pkg::sz_t            root
);
  import osd_pkg::*;

  logic [2*QB-1:0] rad_r  [QB+1];
  logic [QB+1:0]   rem_r  [QB+1];
  sz_t             root_r [QB+1];
  logic            sat_r  [QB+1];

  logic [2*QB-1:0] rad_nxt  [QB+1];
  logic [QB+1:0]   rem_nxt  [QB+1];
  sz_t             root_nxt [QB+1];
  logic            sat_nxt  [QB+1];
  logic [SQ_W-1:0] sum;

  always_comb begin
    sum         = {1'b0, x0} + {1'b0, x1};
    rad_nxt[0]  = sum[2*QB-1:0];
    sat_nxt[0]  = (sum[SQ_W-1:2*QB] != '0);
    rem_nxt[0]  = '0;
    root_nxt[0] = '0;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [QB+3:0] shf;
    logic [QB+3:0] trial;
    logic [QB+3:0] sub;
    logic          ge;
    always_comb begin
      shf   = {rem_r[k-1], rad_r[k-1][2*QB-1 -: 2]};
      trial = {2'b00, root_r[k-1], 2'b01};
      sub   = shf - trial;
      ge    = (shf >= trial);
      rem_nxt[k]  = ge ? sub[QB+1:0] : shf[QB+1:0];
      root_nxt[k] = {root_r[k-1][QB-2:0], ge};
      rad_nxt[k]  = rad_r[k-1] << 2;
      sat_nxt[k]  = sat_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= QB; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        sat_r[k]  <= sat_nxt[k];
      end
    end
  end

  assign root = sat_r[QB] ? QMAX : root_r[QB];

endmodule

// ===== hdl/osd_check.sv =====
// Port-level checker for the orthoplex distance block, bound to the top level.
`timescale 1ns / 1ps
module osd_check (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input osd_pkg::out_t out_data,
  input logic          pready
);
  import osd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result beat changed");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) pready)
    else $error("config port not ready");

endmodule

bind orthoplex_signed_distance osd_check u_osd_check (.*);

// ===== tb/tb_orthoplex_signed_distance.sv =====
// Self-checking testbench for the orthoplex signed distance block.
`timescale 1ns / 1ps
module tb_orthoplex_signed_distance;
  import osd_pkg::*;

  localparam int LATENCY = 71;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [ADDR_W-1:0] REG_SIZE_X = 4'd0;
  localparam logic [ADDR_W-1:0] REG_SIZE_Y = 4'd4;
  localparam logic [ADDR_W-1:0] REG_SIZE_Z = 4'd8;
  localparam logic [ADDR_W-1:0] REG_SIZE_W = 4'd12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  orthoplex_signed_distance u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [30:0] axis_size [4];
  in_t point_queue [$];
  out_t distance_queue [$];
  int send_idle_pct = 17;
  int recv_idle_pct = 83;
  int hold_off_cycles = 0;
  int idle_cycles = 0;
  bit failed = 0;

  function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic out_t predict_distance(input in_t pt);
    logic signed [63:0] p [4];
    logic signed [63:0] q [4];
    logic signed [63:0] n [4];
    logic signed [63:0] d, fd4, t, sum;
    logic [63:0] a, qq, m, prod, e, dist_q;
    logic [127:0] sq, r, c;
    out_t res;
    bit neg;
    p[0] = pt.point_x; p[1] = pt.point_y; p[2] = pt.point_z; p[3] = pt.point_w;
    if (p[0] == 0 && p[1] == 0 && p[2] == 0 && p[3] == 0) begin
      res = '0;
      res.signed_distance = -word_t'(axis_size[0] >> 1);
      res.nearest_x = word_t'(axis_size[0] >> 1);
      return res;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      a = magnitude(p[i]);
      if (axis_size[i] == 0) qq = (a != 0) ? 64'h7FFF_FFFF : 64'd0;
      else qq = (a << 16) / axis_size[i];
      if (qq > 64'h7FFF_FFFF) qq = 64'h7FFF_FFFF;
      q[i] = $signed(qq);
      sum += q[i];
    end
    d = sum - 64'sd65536;
    fd4 = d >= 0 ? d / 4 : -((-d + 3) / 4);
    for (int i = 0; i < 4; i++) begin
      t = clamp_word(q[i] - fd4);
      m = magnitude(t);
      if (p[i] == 0 || t == 0 || axis_size[i] == 0) begin
        n[i] = 0;
      end else begin
        prod = (m * axis_size[i]) >> 16;
        if (prod > 64'h8000_0000) prod = 64'h8000_0000;
        neg = (p[i] < 0) != (t < 0);
        n[i] = neg ? clamp_word(-$signed(prod)) : clamp_word($signed(prod));
      end
    end
    sq = 0;
    for (int i = 0; i < 4; i++) begin
      e = magnitude(p[i] - n[i]);
      sq += 128'(e) * 128'(e);
    end
    r = 0;
    for (int b = 50; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sq) r = c;
    end
    dist_q = r[63:0];
    if (dist_q > 64'h7FFF_FFFF) dist_q = 64'h7FFF_FFFF;
    res.signed_distance = word_t'(d < 0 ? -$signed(dist_q) : $signed(dist_q));
    res.nearest_x = word_t'(n[0]);
    res.nearest_y = word_t'(n[1]);
    res.nearest_z = word_t'(n[2]);
    res.nearest_w = word_t'(n[3]);
    return res;
  endfunction

  // driver: predict at acceptance so config changes between phases are honored
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      distance_queue.push_back(predict_distance(in_data));
    end
    if (!in_valid || !in_stall) begin
      if (point_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= point_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t exp_res;
    if (out_valid && !out_stall) begin
      if (distance_queue.size() == 0) begin
        $error("unexpected beat %h", out_data);
        failed = 1;
      end else begin
        exp_res = distance_queue.pop_front();
        if (out_data.signed_distance !== exp_res.signed_distance) begin
          $error("signed_distance exp %h got %h", exp_res.signed_distance,
                 out_data.signed_distance);
          failed = 1;
        end
        if (out_data.nearest_x !== exp_res.nearest_x) begin
          $error("nearest_x exp %h got %h", exp_res.nearest_x, out_data.nearest_x);
          failed = 1;
        end
        if (out_data.nearest_y !== exp_res.nearest_y) begin
          $error("nearest_y exp %h got %h", exp_res.nearest_y, out_data.nearest_y);
          failed = 1;
        end
        if (out_data.nearest_z !== exp_res.nearest_z) begin
          $error("nearest_z exp %h got %h", exp_res.nearest_z, out_data.nearest_z);
          failed = 1;
        end
        if (out_data.nearest_w !== exp_res.nearest_w) begin
          $error("nearest_w exp %h got %h", exp_res.nearest_w, out_data.nearest_w);
          failed = 1;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[orthoplex_signed_distance] ERROR");
      $finish;
    end
  end

  task automatic write_size(input logic [ADDR_W-1:0] addr, input logic [30:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {1'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    axis_size[addr >> 2] = val;
  endtask

  task automatic set_sizes(input logic [30:0] sx, sy, sz, sw);
    write_size(REG_SIZE_X, sx);
    write_size(REG_SIZE_Y, sy);
    write_size(REG_SIZE_Z, sz);
    write_size(REG_SIZE_W, sw);
  endtask

  task automatic drain();
    while (point_queue.size() > 0 || in_valid || distance_queue.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic word_t rand_coord();
    case ($urandom_range(5))
      0: return word_t'($urandom());
      1: return word_t'($signed($urandom_range(131072)) - 65536);
      2: return word_t'($signed($urandom_range(1048576)) - 524288);
      3: return 0;
      4: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return word_t'($signed($urandom_range(16777216)) - 8388608);
    endcase
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(3))
      0: return 31'($urandom_range(262144, 16384));
      1: return 31'($urandom_range(31'h7FFF_FFFF, 1));
      2: return 31'($urandom_range(256, 1));
      default: return 31'h7FFF_FFFF;
    endcase
  endfunction

  task automatic queue_random(input int count);
    in_t pt;
    repeat (count) begin
      pt.point_x = rand_coord(); pt.point_y = rand_coord();
      pt.point_z = rand_coord(); pt.point_w = rand_coord();
      point_queue.push_back(pt);
    end
  endtask

  initial begin
    in_t pt;
    foreach (axis_size[i]) axis_size[i] = 31'd65536;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    point_queue.push_back('0);
    point_queue.push_back('{32'sh10000, 0, 0, 0});
    point_queue.push_back('{0, -32'sh10000, 0, 0});
    point_queue.push_back('{32'sh4000, 32'sh4000, 32'sh4000, 32'sh4000});
    point_queue.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    point_queue.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    point_queue.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1});
    point_queue.push_back('{1, -1, 1, -1});
    point_queue.push_back('{-32'sh2000, 32'sh3000, -32'sh100, 0});
    point_queue.push_back('{32'shFFFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F});
    drain();

    set_sizes(31'h7FFF_FFFF, 31'd1, 31'd1, 31'h7FFF_FFFF);
    point_queue.push_back('0);
    point_queue.push_back('{32'sh7FFF_FFFF, 1, -1, 32'sh8000_0000});
    point_queue.push_back('{32'sh10000, 32'sh10000, 0, 32'sh10000});
    queue_random(5);
    drain();

    set_sizes(31'd1, 31'd2, 31'd65536, 31'd131072);
    point_queue.push_back('0);
    queue_random(6);
    drain();

    send_idle_pct = 17; recv_idle_pct = 83;
    set_sizes(rand_size(), rand_size(), rand_size(), rand_size());
    queue_random(280);
    drain();

    send_idle_pct = 83; recv_idle_pct = 17;
    set_sizes(rand_size(), rand_size(), rand_size(), rand_size());
    queue_random(280);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    set_sizes(31'd65536, rand_size(), rand_size(), rand_size());
    hold_off_cycles = 300;
    queue_random(290);
    drain();

    if (!failed) begin
      $display("[orthoplex_signed_distance] OK");
    end else begin
      $display("[orthoplex_signed_distance] ERROR");
    end
    $finish;
  end
endmodule
